// ===== rtl/core/ogpc_pkg.sv =====
// Shared types, constants and helper functions of the outlined glyph pixel classifier.
`default_nettype none
package ogpc_pkg;

  localparam int SCREEN_SIZE    = 64;
  localparam int MAX_BOX_WIDTH  = 16;
  localparam int MAX_BOX_HEIGHT = 24;
  localparam int GLYPH_COLS     = 4;
  localparam int GLYPH_ROWS     = 6;
  localparam int XY_W           = 6;

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_FILL    = 2'd1;
  localparam logic [1:0] KIND_OUTLINE = 2'd2;

  localparam logic [1:0] REG_CELL_SCALE = 2'd0;
  localparam logic [1:0] REG_FILL_COLOR = 2'd1;
  localparam logic [1:0] REG_EDGE_COLOR = 2'd2;

  typedef struct packed {
    logic [23:0]       glyph_rows;
    logic signed [7:0] origin_x;
    logic signed [7:0] origin_y;
    logic [3:0]        offset_x;
    logic [4:0]        offset_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  pixel_kind;
    logic [5:0]  screen_x;
    logic [5:0]  screen_y;
    logic [15:0] pixel_color;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  cell_scale;
    logic [15:0] fill_color;
    logic [15:0] edge_color;
  } cfg_t;

  // Stage 1 result: screen position, liveness and the glyph cell of each neighbor line.
  typedef struct packed {
    logic            live;
    logic [XY_W-1:0] sx;
    logic [XY_W-1:0] sy;
    logic [23:0]     glyph_rows;
    logic [2:0][1:0] col;
    logic [2:0]      col_ok;
    logic [2:0][2:0] row;
    logic [2:0]      row_ok;
  } s1_t;

  // Stage 2 result: the covering dot of the pixel and whether any of its eight neighbors is set.
  typedef struct packed {
    logic            live;
    logic [XY_W-1:0] sx;
    logic [XY_W-1:0] sy;
    logic            center;
    logic            near;
  } s2_t;

  // Glyph cell that covers a box pixel coordinate; scales above four are never drawn.
  function automatic logic [2:0] cell_index(input logic [4:0] v, input logic [2:0] scale);
    logic [4:0] q;
    logic [9:0] prod;
    // Multiplying by 11 and dropping five bits divides any 5-bit value by three exactly.
    prod = {5'd0, v} * 10'd11;
    case (scale)
      3'd1: q = v;
      3'd2: q = v >> 1;
      3'd3: q = prod[9:5];
      3'd4: q = v >> 2;
      default: q = '0;
    endcase
    return q[2:0];
  endfunction

  // One dot of the glyph; row 0 sits in the top nibble, column 0 in each nibble's MSB.
  function automatic logic glyph_dot(input logic [23:0] rows, input logic [2:0] r,
                                     input logic [1:0] c);
    logic [3:0] nib;
    case (r)
      3'd0: nib = rows[23:20];
      3'd1: nib = rows[19:16];
      3'd2: nib = rows[15:12];
      3'd3: nib = rows[11:8];
      3'd4: nib = rows[7:4];
      3'd5: nib = rows[3:0];
      default: nib = '0;
    endcase
    return nib[2'd3 - c];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/outlined_glyph_pixel_classifier.sv =====
// Top level of the outlined glyph pixel classifier.
`default_nettype none
// Classifies one pixel of a 4x6 glyph magnified by cell_scale and given a one-pixel outline.
// Input channel: a transaction is taken at each rising edge with start high and busy low.
// busy is always low, so a new pixel can be issued every clock cycle.
// Result channel: out_valid marks a result on out_data for exactly one cycle; the
// receiver takes it at the edge that ends that cycle and has no way to hold it off.
// Three register stages (locate, dot fetch, classify) lie between a taken pixel and its
// result on out_data. Throughput: one pixel per clock, set by the fully pipelined
// datapath with no shared unit.
// Each accepted pixel gives exactly one result; pixel_kind is zero for a blank, out of
// box or clipped pixel, and then the coordinates and color are zero too.
// Configuration: APB-style, cell_scale at 0x0, fill_color at 0x4, edge_color at 0x8;
// write only while no pixel is in flight. pready is always high.
// Reset (synchronous, rst_n low) clears the pipeline valid bits and loads cell_scale 2
// and both colors 0.
module outlined_glyph_pixel_classifier (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire ogpc_pkg::in_item_t  in_data,
  output logic                     out_valid,
  output ogpc_pkg::out_item_t      out_data,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  ogpc_pkg::cfg_t  cfg;
  ogpc_pkg::s1_t   s1;
  ogpc_pkg::s2_t   s2;
  logic            s1_vld, s2_vld;
  logic            in_vld;

  assign busy   = 1'b0;
  assign in_vld = start && !busy;

  ogpc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ogpc_locate u_locate (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_vld),
    .in_item (in_data),
    .cfg     (cfg),
    .s1_vld  (s1_vld),
    .s1      (s1)
  );

  ogpc_dots u_dots (
    .clk    (clk),
    .rst_n  (rst_n),
    .s1_vld (s1_vld),
    .s1     (s1),
    .s2_vld (s2_vld),
    .s2     (s2)
  );

  ogpc_classify u_classify (
    .clk      (clk),
    .rst_n    (rst_n),
    .s2_vld   (s2_vld),
    .s2       (s2),
    .cfg      (cfg),
    .out_vld  (out_valid),
    .out_item (out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/core/ogpc_cfg.sv =====
// APB-style configuration registers of the glyph classifier.
`default_nettype none
module ogpc_cfg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output ogpc_pkg::cfg_t     cfg
);

  logic [2:0]  cell_scale_r, cell_scale_nxt;
  logic [15:0] fill_color_r, fill_color_nxt;
  logic [15:0] edge_color_r, edge_color_nxt;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cell_scale_nxt = cell_scale_r;
    fill_color_nxt = fill_color_r;
    edge_color_nxt = edge_color_r;
    if (wr_en) begin
      case (paddr[3:2])
        ogpc_pkg::REG_CELL_SCALE: cell_scale_nxt = pwdata[2:0];
        ogpc_pkg::REG_FILL_COLOR: fill_color_nxt = pwdata[15:0];
        ogpc_pkg::REG_EDGE_COLOR: edge_color_nxt = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_scale_r <= 3'd2;
      fill_color_r <= '0;
      edge_color_r <= '0;
    end else begin
      cell_scale_r <= cell_scale_nxt;
      fill_color_r <= fill_color_nxt;
      edge_color_r <= edge_color_nxt;
    end
  end

  always_comb begin
    case (paddr[3:2])
      ogpc_pkg::REG_CELL_SCALE: prdata = {29'd0, cell_scale_r};
      ogpc_pkg::REG_FILL_COLOR: prdata = {16'd0, fill_color_r};
      ogpc_pkg::REG_EDGE_COLOR: prdata = {16'd0, edge_color_r};
      default:                  prdata = '0;
    endcase
  end

  assign cfg = '{cell_scale: cell_scale_r, fill_color: fill_color_r,
                 edge_color: edge_color_r};

endmodule
`default_nettype wire

// ===== rtl/core/ogpc_locate.sv =====
// Pipeline stage 1: box and clip checks, screen position and neighbor cell indices.
`default_nettype none
module ogpc_locate (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_vld,
  input  wire ogpc_pkg::in_item_t  in_item,
  input  wire ogpc_pkg::cfg_t      cfg,
  output logic                     s1_vld,
  output ogpc_pkg::s1_t            s1
);

  logic                s1_vld_r;
  ogpc_pkg::s1_t       s1_r, s1_nxt;
  logic [5:0]          box_w, box_h;
  logic                box_ok, in_box, clip_ok;
  logic signed [8:0]   sx, sy;
  logic [5:0]          nx, ny;
  logic [2:0]          col_q;

  always_comb begin
    box_w   = {1'b0, cfg.cell_scale, 2'b00};
    box_h   = 6'(cfg.cell_scale) * 6'd6;
    box_ok  = (cfg.cell_scale != 3'd0) && (int'(box_w) <= ogpc_pkg::MAX_BOX_WIDTH) &&
              (int'(box_h) <= ogpc_pkg::MAX_BOX_HEIGHT);
    in_box  = ({2'b00, in_item.offset_x} < box_w) && ({1'b0, in_item.offset_y} < box_h);
    sx      = 9'(in_item.origin_x) + $signed({5'd0, in_item.offset_x});
    sy      = 9'(in_item.origin_y) + $signed({4'd0, in_item.offset_y});
    clip_ok = (sx >= 0) && (sx < ogpc_pkg::SCREEN_SIZE) &&
              (sy >= 0) && (sy < ogpc_pkg::SCREEN_SIZE);

    s1_nxt.live       = box_ok && in_box && clip_ok;
    s1_nxt.sx         = sx[ogpc_pkg::XY_W-1:0];
    s1_nxt.sy         = sy[ogpc_pkg::XY_W-1:0];
    s1_nxt.glyph_rows = in_item.glyph_rows;

    // A neighbor one step before the box edge wraps to a large value and fails the bound.
    for (int i = 0; i < 3; i++) begin
      nx = {2'b00, in_item.offset_x} + 6'(i) - 6'd1;
      ny = {1'b0, in_item.offset_y} + 6'(i) - 6'd1;
      s1_nxt.col_ok[i] = nx < box_w;
      s1_nxt.row_ok[i] = ny < box_h;
      col_q            = ogpc_pkg::cell_index(nx[4:0], cfg.cell_scale);
      s1_nxt.col[i]    = col_q[1:0];
      s1_nxt.row[i]    = ogpc_pkg::cell_index(ny[4:0], cfg.cell_scale);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  assign s1_vld = s1_vld_r;
  assign s1     = s1_r;

endmodule
`default_nettype wire

// ===== rtl/core/ogpc_dots.sv =====
// Pipeline stage 2: fetches the covering dot of the pixel and its eight neighbors.
`default_nettype none
module ogpc_dots (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           s1_vld,
  input  wire ogpc_pkg::s1_t  s1,
  output logic                s2_vld,
  output ogpc_pkg::s2_t       s2
);

  logic                s2_vld_r;
  ogpc_pkg::s2_t       s2_r, s2_nxt;
  logic [2:0][2:0]     dot;

  always_comb begin
    for (int y = 0; y < 3; y++) begin
      for (int x = 0; x < 3; x++) begin
        dot[y][x] = s1.row_ok[y] && s1.col_ok[x] &&
                    ogpc_pkg::glyph_dot(s1.glyph_rows, s1.row[y], s1.col[x]);
      end
    end
    s2_nxt.live   = s1.live;
    s2_nxt.sx     = s1.sx;
    s2_nxt.sy     = s1.sy;
    s2_nxt.center = dot[1][1];
    s2_nxt.near   = dot[0][0] | dot[0][1] | dot[0][2] | dot[1][0] |
                    dot[1][2] | dot[2][0] | dot[2][1] | dot[2][2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s2_r <= s2_nxt;
  end

  assign s2_vld = s2_vld_r;
  assign s2     = s2_r;

endmodule
`default_nettype wire

// ===== rtl/core/ogpc_classify.sv =====
// Pipeline stage 3: picks fill, outline or no write and registers the result.
`default_nettype none
module ogpc_classify (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            s2_vld,
  input  wire ogpc_pkg::s2_t   s2,
  input  wire ogpc_pkg::cfg_t  cfg,
  output logic                 out_vld,
  output ogpc_pkg::out_item_t  out_item
);

  logic                  out_vld_r;
  ogpc_pkg::out_item_t   out_r, out_nxt;

  always_comb begin
    out_nxt = '0;
    if (s2.live && s2.center) begin
      out_nxt.pixel_kind  = ogpc_pkg::KIND_FILL;
      out_nxt.pixel_color = cfg.fill_color;
    end else if (s2.live && s2.near) begin
      out_nxt.pixel_kind  = ogpc_pkg::KIND_OUTLINE;
      out_nxt.pixel_color = cfg.edge_color;
    end
    // Coordinates are reported only for a pixel that is written.
    if (out_nxt.pixel_kind != ogpc_pkg::KIND_NONE) begin
      out_nxt.screen_x = s2.sx;
      out_nxt.screen_y = s2.sy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_vld  = out_vld_r;
  assign out_item = out_r;

endmodule
`default_nettype wire

// ===== sim/outlined_glyph_pixel_classifier_tb.sv =====
// Self-checking testbench for the outlined glyph pixel classifier.
`timescale 1ns / 1ps

module outlined_glyph_pixel_classifier_tb;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int STALL_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 8;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  ogpc_pkg::in_item_t  pix_in = '0;
  logic                out_valid;
  ogpc_pkg::out_item_t pix_out;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [3:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  // Register copies that the prediction uses.
  logic [2:0]  dot_scale = 3'd2;
  logic [15:0] body_rgb = 16'h0000;
  logic [15:0] outline_rgb = 16'h0000;

  ogpc_pkg::in_item_t  pixels_to_send [$];
  ogpc_pkg::out_item_t expected_writes [$];
  ogpc_pkg::out_item_t mon_want;

  int  gap_left = 0;
  int  issued_cnt = 0;
  bit  drain_hold = 1'b0;
  bit  steady_run = 1'b0;
  int  err_cnt = 0;
  int  stall_cycles = 0;
  int  fill_cnt = 0;
  int  outline_cnt = 0;
  int  blank_cnt = 0;
  int  setting_cnt = 0;

  outlined_glyph_pixel_classifier u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (pix_in),
    .out_valid (out_valid),
    .out_data  (pix_out),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // True when box pixel (px, py) lies inside the scaled box and its glyph dot is set.
  function automatic bit dot_lit(input logic [23:0] rows, input int scale, input int px,
                                 input int py);
    int r;
    int c;
    if (px < 0 || py < 0 || px >= 4 * scale || py >= 6 * scale) return 1'b0;
    r = py / scale;
    c = px / scale;
    return rows[23 - (4 * r + c)];
  endfunction

  function automatic ogpc_pkg::out_item_t classify_pixel(input ogpc_pkg::in_item_t p);
    ogpc_pkg::out_item_t res;
    int scale;
    int px;
    int py;
    int sx;
    int sy;
    bit near;
    res = '0;
    scale = int'(dot_scale);
    px = int'(p.offset_x);
    py = int'(p.offset_y);
    sx = int'($signed(p.origin_x)) + px;
    sy = int'($signed(p.origin_y)) + py;
    near = 1'b0;
    if (scale == 0 || 4 * scale > ogpc_pkg::MAX_BOX_WIDTH ||
        6 * scale > ogpc_pkg::MAX_BOX_HEIGHT) return res;
    if (px >= 4 * scale || py >= 6 * scale) return res;
    if (sx < 0 || sx >= ogpc_pkg::SCREEN_SIZE || sy < 0 || sy >= ogpc_pkg::SCREEN_SIZE)
      return res;
    for (int dy = -1; dy <= 1; dy++)
      for (int dx = -1; dx <= 1; dx++)
        if ((dx != 0 || dy != 0) && dot_lit(p.glyph_rows, scale, px + dx, py + dy))
          near = 1'b1;
    if (dot_lit(p.glyph_rows, scale, px, py)) begin
      res.pixel_kind = ogpc_pkg::KIND_FILL;
      res.pixel_color = body_rgb;
    end else if (near) begin
      res.pixel_kind = ogpc_pkg::KIND_OUTLINE;
      res.pixel_color = outline_rgb;
    end
    if (res.pixel_kind != ogpc_pkg::KIND_NONE) begin
      res.screen_x = sx[5:0];
      res.screen_y = sy[5:0];
    end
    return res;
  endfunction

  function automatic ogpc_pkg::in_item_t make_pixel(input logic [23:0] rows, input int ox,
                                                    input int oy, input int px,
                                                    input int py);
    ogpc_pkg::in_item_t p;
    p.glyph_rows = rows;
    p.origin_x = 8'(ox);
    p.origin_y = 8'(oy);
    p.offset_x = 4'(px);
    p.offset_y = 5'(py);
    return p;
  endfunction

  // Mostly pixels inside the box near the screen for a drawable scale, the rest with every field at random.
  function automatic ogpc_pkg::in_item_t random_pixel(input int scale);
    ogpc_pkg::in_item_t p;
    case ($urandom_range(0, 3))
      0: p.glyph_rows = 24'($urandom);
      1: p.glyph_rows = 24'($urandom & $urandom & $urandom);
      2: p.glyph_rows = 24'($urandom | $urandom);
      default: p.glyph_rows = 24'(32'h1 << $urandom_range(0, 23));
    endcase
    if ($urandom_range(0, 99) < 75 && scale >= 1 && scale <= 4) begin
      p.origin_x = 8'(int'($urandom_range(0, 71)) - 8);
      p.origin_y = 8'(int'($urandom_range(0, 71)) - 8);
      p.offset_x = 4'($urandom_range(0, 4 * scale - 1));
      p.offset_y = 5'($urandom_range(0, 6 * scale - 1));
    end else begin
      p.origin_x = 8'($urandom_range(0, 255));
      p.origin_y = 8'($urandom_range(0, 255));
      p.offset_x = 4'($urandom_range(0, 15));
      p.offset_y = 5'($urandom_range(0, 23));
    end
    return p;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_run || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      ogpc_pkg::REG_CELL_SCALE: dot_scale = val[2:0];
      ogpc_pkg::REG_FILL_COLOR: body_rgb = val[15:0];
      ogpc_pkg::REG_EDGE_COLOR: outline_rgb = val[15:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input int scale, input logic [15:0] fill,
                              input logic [15:0] outline);
    reg_write(ogpc_pkg::REG_CELL_SCALE, 32'(scale));
    reg_write(ogpc_pkg::REG_FILL_COLOR, {16'h0, fill});
    reg_write(ogpc_pkg::REG_EDGE_COLOR, {16'h0, outline});
    setting_cnt++;
    @(negedge clk);
  endtask

  // Returns at a falling edge once every queued pixel is taken and its result checked.
  task automatic wait_drained();
    do @(negedge clk);
    while (pixels_to_send.size() != 0 || start || expected_writes.size() != 0);
  endtask

  // Driver: issues queued pixels with random gaps and an occasional full drain.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
      drain_hold <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) expected_writes.push_back(classify_pixel(pix_in));
      if (drain_hold) begin
        start <= 1'b0;
        if (!start && expected_writes.size() == 0) drain_hold <= 1'b0;
      end else if (gap_left != 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pixels_to_send.size() != 0) begin
        start <= 1'b1;
        pix_in <= pixels_to_send.pop_front();
        gap_left <= pick_gap();
        issued_cnt <= issued_cnt + 1;
        if (issued_cnt % 64 == 63 || $urandom_range(0, 79) == 0) drain_hold <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every result is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_writes.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("Unexpected result with nothing pending: kind %0d x %0d y %0d color %h",
                   pix_out.pixel_kind, pix_out.screen_x, pix_out.screen_y,
                   pix_out.pixel_color);
      end else begin
        mon_want = expected_writes.pop_front();
        case (mon_want.pixel_kind)
          ogpc_pkg::KIND_FILL: fill_cnt++;
          ogpc_pkg::KIND_OUTLINE: outline_cnt++;
          default: blank_cnt++;
        endcase
        if (pix_out.pixel_kind !== mon_want.pixel_kind ||
            pix_out.screen_x !== mon_want.screen_x ||
            pix_out.screen_y !== mon_want.screen_y ||
            pix_out.pixel_color !== mon_want.pixel_color) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("Mismatch (kind/x/y/color): expected %0d/%0d/%0d/%h, got %0d/%0d/%0d/%h",
                     mon_want.pixel_kind, mon_want.screen_x, mon_want.screen_y,
                     mon_want.pixel_color, pix_out.pixel_kind, pix_out.screen_x,
                     pix_out.screen_y, pix_out.pixel_color);
        end
      end
    end
  end

  // A long stretch with no transaction on either side means the block has hung.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout after %0d idle cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int scale;
    int batch;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Register values straight out of reset.
    setting_cnt = 1;
    pixels_to_send.push_back(make_pixel(24'hFFFFFF, 0, 0, 0, 0));
    pixels_to_send.push_back(make_pixel(24'h000000, 10, 10, 3, 3));
    pixels_to_send.push_back(make_pixel(24'h800000, 5, 5, 2, 2));
    wait_drained();

    // Unit scale: diagonal and side outlines, box edge and clipping at the left, right and top screen sides.
    program_regs(1, 16'hFFFF, 16'h07E0);
    reg_write(REG_SPARE, 32'hFFFF_FFFF);
    @(negedge clk);
    pixels_to_send.push_back(make_pixel(24'h800000, 0, 0, 1, 1));
    pixels_to_send.push_back(make_pixel(24'h800000, 0, 0, 1, 0));
    pixels_to_send.push_back(make_pixel(24'h800000, 0, 0, 2, 0));
    pixels_to_send.push_back(make_pixel(24'h100000, 0, 0, 4, 0));
    pixels_to_send.push_back(make_pixel(24'h000001, 20, 30, 3, 5));
    pixels_to_send.push_back(make_pixel(24'hFFFFFF, -128, 0, 0, 0));
    pixels_to_send.push_back(make_pixel(24'hFFFFFF, 127, 0, 0, 0));
    pixels_to_send.push_back(make_pixel(24'hFFFFFF, 60, 60, 3, 3));
    pixels_to_send.push_back(make_pixel(24'hFFFFFF, 61, 0, 3, 0));
    pixels_to_send.push_back(make_pixel(24'hFFFFFF, 0, -1, 0, 0));
    pixels_to_send.push_back(make_pixel(24'hFFFFFF, 0, -1, 0, 1));
    pixels_to_send.push_back(make_pixel(24'hFFFFFF, 0, 0, 15, 23));
    wait_drained();

    // Largest drawable scale: the far corner of the box and a blown-up single dot.
    program_regs(4, 16'h0000, 16'hFFFF);
    pixels_to_send.push_back(make_pixel(24'hFFFFFF, 0, 0, 15, 23));
    pixels_to_send.push_back(make_pixel(24'h000000, 0, 0, 15, 23));
    pixels_to_send.push_back(make_pixel(24'h040000, 0, 0, 3, 3));
    pixels_to_send.push_back(make_pixel(24'h040000, 0, 0, 8, 8));
    pixels_to_send.push_back(make_pixel(24'h040000, 0, 0, 9, 8));
    pixels_to_send.push_back(make_pixel(24'hFFFFFF, -128, -128, 15, 23));
    wait_drained();

    // Empty box and boxes too large to draw.
    program_regs(0, 16'h1234, 16'h5678);
    pixels_to_send.push_back(make_pixel(24'hFFFFFF, 0, 0, 0, 0));
    wait_drained();
    program_regs(7, 16'h1234, 16'h5678);
    pixels_to_send.push_back(make_pixel(24'hFFFFFF, 0, 0, 0, 0));
    wait_drained();
    program_regs(5, 16'h1234, 16'h5678);
    pixels_to_send.push_back(make_pixel(24'hFFFFFF, 0, 0, 1, 1));
    wait_drained();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        4: scale = 0;
        7: scale = 6;
        default: scale = ph % 4 + 1;
      endcase
      case (ph)
        0: program_regs(scale, 16'hFFFF, 16'h0000);
        1: program_regs(scale, 16'h0000, 16'hFFFF);
        default: program_regs(scale, 16'($urandom), 16'($urandom));
      endcase
      steady_run = (ph == 2 || ph == 6);
      batch = (scale >= 1 && scale <= 4) ? 50 : 15;
      repeat (batch) pixels_to_send.push_back(random_pixel(scale));
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_writes.size() != 0) begin
      $display("%0d predicted results never arrived", expected_writes.size());
      err_cnt += expected_writes.size();
    end
    $display("Checked %0d pixels (%0d fill, %0d outline, %0d no write) under %0d settings.",
             fill_cnt + outline_cnt + blank_cnt, fill_cnt, outline_cnt, blank_cnt,
             setting_cnt);
    $display("Scales 0 to 7 were used, with clipping on all sides and mismatches seen: %0d.",
             err_cnt);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
